@@ src/hpt_pkg.sv @@
package hpt_pkg;

  // Default table depth and register reset values.
  localparam int NODE_SLOTS_DEF = 16;
  localparam logic [15:0] HB_INTERVAL_RST = 16'd1000;
  localparam logic [15:0] OFF_TIMEOUT_RST = 16'd3000;

  // Configuration register indexes.
  localparam logic CFG_HEARTBEAT_INTERVAL = 1'b0;
  localparam logic CFG_OFFLINE_TIMEOUT = 1'b1;

  // Item modes.
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_TICK_DONE = 3'd0;
  localparam logic [2:0] STAT_STORED = 3'd1;
  localparam logic [2:0] STAT_INVALID = 3'd2;
  localparam logic [2:0] STAT_FULL = 3'd3;
  localparam logic [2:0] STAT_READ = 3'd4;

  // One table slot as held in the slot memory.
  typedef struct packed {
    logic [7:0]  node_id;
    logic [7:0]  zones;
    logic [7:0]  outputs;
    logic [7:0]  tx_err;
    logic [7:0]  rx_err;
    logic        online;
    logic [31:0] seen;
  } slot_t;

  // Flags from the shared age compare unit.
  typedef struct packed {
    logic ge;
    logic gt;
  } age_cmp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_BEAT,
    S_SCAN,
    S_STORE,
    S_READ_ADDR,
    S_READ_DATA
  } state_t;

endpackage

@@ src/hpt_age_unit.sv @@
module hpt_age_unit (
  input  logic [31:0]      now,
  input  logic [31:0]      stamp,
  input  logic [15:0]      limit,
  output hpt_pkg::age_cmp_t cmp
);

  logic [31:0] age;

  // Elapsed ticks wrap modulo 2^32, then compare against the limit.
  assign age = now - stamp;
  assign cmp.ge = (age >= 32'(limit));
  assign cmp.gt = (age > 32'(limit));

endmodule

@@ src/hpt_slot_mem.sv @@
module hpt_slot_mem #(
  parameter int NODE_SLOTS = hpt_pkg::NODE_SLOTS_DEF,
  localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  hpt_pkg::slot_t        wr_data,
  input  logic [IW-1:0]         rd_addr,
  output hpt_pkg::slot_t        rd_data
);

  hpt_pkg::slot_t mem [NODE_SLOTS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/node_heartbeat_presence_table.sv @@
// Heartbeat presence table for bus nodes.
// Command channel: present mode and the frame or read fields with start while
// busy is low; the item is taken at that clock edge. Modes are a time tick,
// a received heartbeat frame and a slot read. Each item gives exactly one
// result, shown on the result ports for one cycle with done high; the
// receiver cannot stall, so it must take the result in that cycle.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 heartbeat
// interval, 1 offline timeout) at once; write only while busy is low.
// A tick and a frame scan the prefix of occupied slots, reading one slot per
// cycle through the single memory read port; a tick checks each slot with the
// one shared age compare unit, a frame compares its node number. A read goes
// through an address state and a data state; an invalid frame or an unused
// mode finishes from idle. A new item may be started in the cycle in which
// done is high.
// Reset clears time, the heartbeat mark and the used count and loads register
// defaults; every slot then reads as empty, with no slot memory clearing pass.
module node_heartbeat_presence_table #(
  parameter int NODE_SLOTS = hpt_pkg::NODE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  mode,
  input  logic [28:0] frame_id,
  input  logic [3:0]  frame_length,
  input  logic [7:0]  zones_byte,
  input  logic [7:0]  outputs_byte,
  input  logic [7:0]  transmit_errors_byte,
  input  logic [7:0]  receive_errors_byte,
  input  logic [3:0]  read_slot,
  output logic [2:0]  status,
  output logic        send_heartbeat,
  output logic        publish_snapshot,
  output logic [3:0]  slot_index,
  output logic [7:0]  node_number,
  output logic [7:0]  zones_count,
  output logic [7:0]  outputs_count,
  output logic [7:0]  transmit_errors,
  output logic [7:0]  receive_errors,
  output logic        is_online,
  output logic [31:0] last_seen,
  output logic [4:0]  nodes_in_use
);

  localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CW = $clog2(NODE_SLOTS + 1);
  localparam int XW = ((IW > 4) ? IW : 4) + 1;

  typedef struct packed {
    logic [2:0]     status;
    logic           send;
    logic           publish;
    logic [3:0]     slot;
    hpt_pkg::slot_t rec;
    logic [4:0]     used;
  } result_t;

  hpt_pkg::state_t   state;
  hpt_pkg::state_t   state_next;

  logic [15:0]       hb_interval;
  logic [15:0]       off_timeout;
  logic [31:0]       current_time;
  logic [31:0]       last_beat_sent;
  logic [CW-1:0]     used_count;
  logic [CW-1:0]     issue_idx;
  logic              pend_valid;
  logic [IW-1:0]     pend_idx;
  logic [1:0]        mode_q;
  logic [7:0]        id_q;
  logic [3:0]        len_q;
  logic [7:0]        zones_q;
  logic [7:0]        outputs_q;
  logic [7:0]        tx_q;
  logic [7:0]        rx_q;
  logic [3:0]        rslot_q;
  logic              send_q;
  logic              pub_q;
  logic [IW-1:0]     store_slot;
  logic              store_new;
  logic [7:0]        old_tx;
  logic [7:0]        old_rx;
  result_t           res;
  result_t           res_next;
  logic              fin;

  logic              accept;
  logic              frame_ok;
  logic              issue_ok;
  logic              scan_end;
  logic              id_match;
  logic              room;
  logic [XW-1:0]     rslot_ext;
  logic              rslot_range;
  logic              rslot_used;
  logic [CW-1:0]     used_after;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  hpt_pkg::slot_t    mem_wdata;
  logic [IW-1:0]     mem_raddr;
  hpt_pkg::slot_t    mem_rdata;
  hpt_pkg::slot_t    store_rec;

  logic [31:0]       age_stamp;
  logic [15:0]       age_limit;
  hpt_pkg::age_cmp_t age;

  hpt_slot_mem #(
    .NODE_SLOTS(NODE_SLOTS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  hpt_age_unit u_age (
    .now  (current_time),
    .stamp(age_stamp),
    .limit(age_limit),
    .cmp  (age)
  );

  // Status decodes shared by the sequencer blocks.
  assign accept = start && (state == hpt_pkg::S_IDLE);
  assign frame_ok = (frame_id[7:0] != 8'd0) && (frame_length >= 4'd2);
  assign issue_ok = (issue_idx < used_count);
  assign scan_end = !pend_valid && !issue_ok;
  assign id_match = pend_valid && (mem_rdata.node_id == id_q);
  assign room = (used_count < CW'(NODE_SLOTS));
  assign rslot_ext = XW'(rslot_q);
  assign rslot_range = (rslot_ext < XW'(NODE_SLOTS));
  assign rslot_used = (rslot_ext < XW'(used_count));
  assign used_after = used_count + CW'(store_new);

  // Record written by a stored frame; error bytes only for length 4 and up.
  always_comb begin
    store_rec.node_id = id_q;
    store_rec.zones = zones_q;
    store_rec.outputs = outputs_q;
    store_rec.tx_err = (len_q >= 4'd4) ? tx_q : old_tx;
    store_rec.rx_err = (len_q >= 4'd4) ? rx_q : old_rx;
    store_rec.online = 1'b1;
    store_rec.seen = current_time;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      hpt_pkg::S_IDLE: begin
        if (start) begin
          unique case (mode)
            hpt_pkg::MODE_TICK: state_next = hpt_pkg::S_BEAT;
            hpt_pkg::MODE_FRAME: state_next = frame_ok ? hpt_pkg::S_SCAN : hpt_pkg::S_IDLE;
            hpt_pkg::MODE_READ: state_next = hpt_pkg::S_READ_ADDR;
            default: state_next = hpt_pkg::S_IDLE;
          endcase
        end
      end
      hpt_pkg::S_BEAT: state_next = hpt_pkg::S_SCAN;
      hpt_pkg::S_SCAN: begin
        if (mode_q == hpt_pkg::MODE_TICK) begin
          if (scan_end) begin
            state_next = hpt_pkg::S_IDLE;
          end
        end else if (id_match) begin
          state_next = hpt_pkg::S_STORE;
        end else if (scan_end) begin
          state_next = room ? hpt_pkg::S_STORE : hpt_pkg::S_IDLE;
        end
      end
      hpt_pkg::S_STORE: state_next = hpt_pkg::S_IDLE;
      hpt_pkg::S_READ_ADDR: state_next = hpt_pkg::S_READ_DATA;
      hpt_pkg::S_READ_DATA: state_next = hpt_pkg::S_IDLE;
      default: state_next = hpt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: memory ports, compare unit operands and the result.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = pend_idx;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    age_stamp = last_beat_sent;
    age_limit = hb_interval;
    fin = 1'b0;
    res_next = '0;
    res_next.used = 5'(used_count);
    unique case (state)
      hpt_pkg::S_IDLE: begin
        if (start) begin
          if (mode == hpt_pkg::MODE_FRAME && !frame_ok) begin
            fin = 1'b1;
            res_next.status = hpt_pkg::STAT_INVALID;
          end else if (mode != hpt_pkg::MODE_TICK && mode != hpt_pkg::MODE_FRAME &&
                       mode != hpt_pkg::MODE_READ) begin
            fin = 1'b1;
            res_next.status = hpt_pkg::STAT_TICK_DONE;
          end
        end
      end
      hpt_pkg::S_BEAT: begin
        age_stamp = last_beat_sent;
        age_limit = hb_interval;
      end
      hpt_pkg::S_SCAN: begin
        if (issue_ok) begin
          mem_raddr = issue_idx[IW-1:0];
        end
        age_stamp = mem_rdata.seen;
        age_limit = off_timeout;
        if (mode_q == hpt_pkg::MODE_TICK) begin
          // A silent slot goes offline.
          if (pend_valid && age.gt) begin
            mem_we = 1'b1;
            mem_waddr = pend_idx;
            mem_wdata = mem_rdata;
            mem_wdata.online = 1'b0;
          end
          if (scan_end) begin
            fin = 1'b1;
            res_next.status = hpt_pkg::STAT_TICK_DONE;
            res_next.send = send_q;
            res_next.publish = pub_q;
          end
        end else if (!id_match && scan_end && !room) begin
          fin = 1'b1;
          res_next.status = hpt_pkg::STAT_FULL;
        end
      end
      hpt_pkg::S_STORE: begin
        mem_we = 1'b1;
        mem_waddr = store_slot;
        mem_wdata = store_rec;
        fin = 1'b1;
        res_next.status = hpt_pkg::STAT_STORED;
        res_next.publish = 1'b1;
        res_next.slot = 4'(store_slot);
        res_next.rec = store_rec;
        res_next.used = 5'(used_after);
      end
      hpt_pkg::S_READ_ADDR: begin
        if (rslot_range) begin
          mem_raddr = rslot_ext[IW-1:0];
        end
      end
      hpt_pkg::S_READ_DATA: begin
        fin = 1'b1;
        res_next.status = hpt_pkg::STAT_READ;
        res_next.slot = rslot_q;
        if (rslot_range && rslot_used) begin
          res_next.rec = mem_rdata;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Control state, time keeping and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpt_pkg::S_IDLE;
      hb_interval <= hpt_pkg::HB_INTERVAL_RST;
      off_timeout <= hpt_pkg::OFF_TIMEOUT_RST;
      current_time <= '0;
      last_beat_sent <= '0;
      used_count <= '0;
      pend_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= fin;
      if (cfg_we) begin
        unique case (cfg_index)
          hpt_pkg::CFG_HEARTBEAT_INTERVAL: hb_interval <= cfg_data;
          hpt_pkg::CFG_OFFLINE_TIMEOUT: off_timeout <= cfg_data;
          default: hb_interval <= hb_interval;
        endcase
      end
      if (accept && mode == hpt_pkg::MODE_TICK) begin
        current_time <= current_time + 32'd1;
      end
      if (state == hpt_pkg::S_BEAT && age.ge) begin
        last_beat_sent <= current_time;
      end
      if (state == hpt_pkg::S_STORE && store_new) begin
        used_count <= used_after;
      end
      pend_valid <= (state == hpt_pkg::S_SCAN && state_next == hpt_pkg::S_SCAN) ?
                    issue_ok : 1'b0;
    end
  end

  // Item fields, scan pointers and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      id_q <= frame_id[7:0];
      len_q <= frame_length;
      zones_q <= zones_byte;
      outputs_q <= outputs_byte;
      tx_q <= transmit_errors_byte;
      rx_q <= receive_errors_byte;
      rslot_q <= read_slot;
      send_q <= 1'b0;
      pub_q <= 1'b0;
      issue_idx <= '0;
    end
    if (state == hpt_pkg::S_BEAT) begin
      send_q <= age.ge;
    end
    if (state == hpt_pkg::S_SCAN) begin
      if (issue_ok) begin
        issue_idx <= issue_idx + CW'(1);
        pend_idx <= issue_idx[IW-1:0];
      end
      if (mode_q == hpt_pkg::MODE_TICK && pend_valid && age.gt) begin
        pub_q <= 1'b1;
      end
      // Found slot or first free slot at the end of the prefix.
      if (mode_q == hpt_pkg::MODE_FRAME) begin
        if (id_match) begin
          store_slot <= pend_idx;
          store_new <= 1'b0;
          old_tx <= mem_rdata.tx_err;
          old_rx <= mem_rdata.rx_err;
        end else if (scan_end) begin
          store_slot <= used_count[IW-1:0];
          store_new <= 1'b1;
          old_tx <= 8'd0;
          old_rx <= 8'd0;
        end
      end
    end
    if (fin) begin
      res <= res_next;
    end
  end

  assign busy = (state != hpt_pkg::S_IDLE);
  assign status = res.status;
  assign send_heartbeat = res.send;
  assign publish_snapshot = res.publish;
  assign slot_index = res.slot;
  assign node_number = res.rec.node_id;
  assign zones_count = res.rec.zones;
  assign outputs_count = res.rec.outputs;
  assign transmit_errors = res.rec.tx_err;
  assign receive_errors = res.rec.rx_err;
  assign is_online = res.rec.online;
  assign last_seen = res.rec.seen;
  assign nodes_in_use = res.used;

endmodule

@@ src/hpt_checker.sv @@
module hpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic        publish_snapshot,
  input logic [3:0]  slot_index,
  input logic [7:0]  node_number,
  input logic        is_online,
  input logic [31:0] last_seen
);

  // A result is only shown once the sequencer is back to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // An accepted item either keeps the block busy or finishes at once.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted item vanished");

  // Status codes stay in their defined range.
  assert property (@(posedge clk) disable iff (rst) done |-> (status <= hpt_pkg::STAT_READ))
    else $error("status code out of range");

  // Results without a slot carry empty slot fields.
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == hpt_pkg::STAT_TICK_DONE || status == hpt_pkg::STAT_INVALID ||
              status == hpt_pkg::STAT_FULL))
    |-> (slot_index == 4'd0 && node_number == 8'd0 && last_seen == 32'd0))
    else $error("slot fields set on a result without a slot");

  // A stored frame leaves an online, occupied slot and requests a publish.
  assert property (@(posedge clk) disable iff (rst)
    (done && status == hpt_pkg::STAT_STORED)
    |-> (publish_snapshot && is_online && node_number != 8'd0))
    else $error("stored frame result inconsistent");

endmodule

bind node_heartbeat_presence_table hpt_checker u_hpt_checker (.*);
